// ----- hdl/bce_pkg.sv -----
package bce_pkg;

    localparam int MAX_POINTS_DEF      = 64;
    localparam int MAX_DEGREE_DEF      = 4;
    localparam int FRAME_FRAC_BITS_DEF = 8;

    localparam int DEGREE_RESET = 3;
    localparam int POINTS_RESET = 2;

    // Q2.16 basis weight limits and unity
    localparam int W18_MAX = 131071;
    localparam int W18_MIN = -131072;
    localparam int ONE_Q16 = 65536;
    localparam int HALF_Q16 = 32768;

    typedef logic signed [17:0] t_weight;

    typedef enum logic [1:0] {
        KIND_KNOT  = 2'd0,
        KIND_POINT = 2'd1,
        KIND_EVAL  = 2'd2,
        KIND_RSVD  = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_DEGREE = 1'b0,
        CFG_POINTS = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_kind              kind;
        logic [6:0]         slot;
        logic [7:0]         knot_value;
        logic signed [31:0] point_x_in;
        logic signed [31:0] point_y_in;
        logic signed [31:0] point_z_in;
        logic signed [31:0] point_w_in;
        logic [15:0]        frame_time;
    } t_item;

    typedef struct packed {
        logic signed [31:0] curve_x;
        logic signed [31:0] curve_y;
        logic signed [31:0] curve_z;
        logic signed [31:0] curve_w;
        logic [5:0]         span_index;
        logic               zero_span_error;
    } t_result;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } t_point;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOK_N,
        ST_CMP_N,
        ST_CMP_P,
        ST_BIS_RD,
        ST_BIS_CMP,
        ST_INIT,
        ST_RD_A,
        ST_RD_B,
        ST_DEN,
        ST_DIV,
        ST_SIGN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_UPD,
        ST_WR0,
        ST_SUM_RD,
        ST_SUM_MAC,
        ST_FIN
    } t_state;

endpackage

// ----- hdl/bspline_curve_evaluator_core.sv -----
// Channel      Signals                                   Transaction
// ------------ ----------------------------------------- ------------------------------------
// command in   start, busy, i_item                       start high while busy low
// result out   o_result_valid, o_result                  one-cycle strobe, always taken
// config       i_cfg_we, i_cfg_index, i_cfg_data         write at any edge with i_cfg_we high
//
// Knot and control point writes finish in the accepting cycle; busy stays low.
// An evaluate runs knot reads for the span search, then per basis update two knot reads,
// a radix-4 serial divide and a two-pass 18 x 17 multiply, then one 32 x 18 multiplier
// over the four coordinates of each control point; too few points or a zero-width knot
// span ends it with an error result. The result strobe comes in the first cycle with
// busy low; the receiver cannot stall it. Reset is synchronous; knot and point
// stores hold garbage until written.
module bspline_curve_evaluator_core #(
    parameter int MAX_POINTS      = bce_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE      = bce_pkg::MAX_DEGREE_DEF,
    parameter int FRAME_FRAC_BITS = bce_pkg::FRAME_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  bce_pkg::t_item       i_item,
    output logic                 busy,
    output logic                 o_result_valid,
    output bce_pkg::t_result     o_result,
    input  logic                 i_cfg_we,
    input  bce_pkg::t_cfg_index  i_cfg_index,
    input  logic [6:0]           i_cfg_data
);

    localparam int KNOT_DEPTH = MAX_POINTS + 2 * MAX_DEGREE;
    localparam int IX_W       = $clog2(KNOT_DEPTH);
    localparam int CI_W       = $clog2(MAX_POINTS);
    localparam int BI_W       = $clog2(MAX_DEGREE + 1);
    localparam int KA_W       = 8 + FRAME_FRAC_BITS;
    localparam int DIFF_W     = (KA_W > 16) ? KA_W : 16;
    localparam int DW         = DIFF_W + 16 - FRAME_FRAC_BITS;
    localparam int DW_E       = DW + (DW % 2);
    localparam int A_W        = DW_E + 1;
    localparam int AHI_W      = A_W - 17;
    localparam int P_W        = 18 + A_W;
    localparam int R_W        = P_W - 16;
    localparam int S_W        = R_W + 2;
    localparam int ACC_W      = 50 + $clog2(MAX_DEGREE + 2);
    localparam int AR_W       = ACC_W - 16;
    localparam int DIV_STEPS  = DW_E / 2;
    localparam int DC_W       = $clog2(DIV_STEPS + 1);

    localparam logic signed [R_W-1:0]  RW_MAX  = R_W'(bce_pkg::W18_MAX);
    localparam logic signed [R_W-1:0]  RW_MIN  = R_W'(bce_pkg::W18_MIN);
    localparam logic signed [S_W-1:0]  SW_MAX  = S_W'(bce_pkg::W18_MAX);
    localparam logic signed [S_W-1:0]  SW_MIN  = S_W'(bce_pkg::W18_MIN);
    localparam logic signed [AR_W-1:0] OUT_MAX = AR_W'(2147483647);
    localparam logic signed [AR_W-1:0] OUT_MIN = ~OUT_MAX;

    // storage
    logic [7:0]             knot_mem  [KNOT_DEPTH];
    bce_pkg::t_point        ctrl_mem  [MAX_POINTS];
    bce_pkg::t_weight       basis_mem [MAX_DEGREE+1];

    logic [7:0]             r_knot_q;
    bce_pkg::t_point        r_ctrl_q;
    bce_pkg::t_weight       r_basis_q;

    logic                   knot_we, knot_re, ctrl_we, ctrl_re, basis_we, basis_re;
    logic [IX_W-1:0]        knot_wa, knot_ra;
    logic [CI_W-1:0]        ctrl_wa, ctrl_ra;
    logic [BI_W-1:0]        basis_wa, basis_ra;
    bce_pkg::t_weight       basis_wd;

    // control and datapath registers
    bce_pkg::t_state        r_state, n_state;
    logic [2:0]             r_degree, n_degree;
    logic [6:0]             r_points, n_points;
    logic [15:0]            r_t, n_t;
    logic [BI_W-1:0]        r_p, n_p, r_i, n_i, r_j, n_j;
    logic [IX_W-1:0]        r_n, n_n, r_s, n_s, r_lo, n_lo, r_hi, n_hi;
    logic [1:0]             r_c, n_c;
    logic                   r_err, n_err;
    logic [7:0]             r_ka, n_ka;
    bce_pkg::t_weight       r_old, n_old, r_carry, n_carry;
    logic [DW_E-1:0]        r_dvd, n_dvd, r_quot, n_quot;
    logic [7:0]             r_rem, n_rem, r_dvs, n_dvs;
    logic                   r_neg, n_neg;
    logic [DC_W-1:0]        r_dcnt, n_dcnt;
    logic signed [A_W-1:0]  r_a, n_a;
    logic signed [P_W-1:0]  r_prod, n_prod;
    logic signed [ACC_W-1:0] r_acc [4];
    logic signed [ACC_W-1:0] n_acc [4];
    bce_pkg::t_result       r_result, n_result;
    logic                   r_result_valid, n_result_valid;

    // combinational helpers
    logic [BI_W-1:0]        p_sat;
    logic [IX_W-1:0]        n_sat;
    logic                   accept;
    logic [IX_W:0]          mid_sum;
    logic [IX_W-1:0]        mid;
    logic [KA_W-1:0]        kq_sh, ka_sh;
    logic                   t_ge_kq;
    logic signed [8:0]      dk;
    logic signed [DIFF_W:0] diff;
    logic [DIFF_W-1:0]      diff_mag;
    logic [DIFF_W+15:0]     dvd_full;
    logic [7:0]             d_rem;
    logic [8:0]             d_trial;
    logic [DW_E-1:0]        d_dvd, d_quot;
    logic signed [35:0]     mul_lo;
    logic signed [17+AHI_W:0] mul_hi;
    logic signed [P_W-1:0]  prod_r;
    logic signed [R_W-1:0]  tmp_rnd;
    bce_pkg::t_weight       tmp_sat, upd_sat;
    logic signed [S_W-1:0]  upd_sum;
    logic signed [31:0]     mac_comp;
    logic signed [49:0]     mac_p;
    logic signed [ACC_W-1:0] acc_r [4];
    logic signed [AR_W-1:0] acc_rnd [4];
    logic signed [31:0]     acc_out [4];

    assign busy           = (r_state != bce_pkg::ST_IDLE);
    assign accept         = start && !busy;
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    // saturate registers to the supported ranges
    always_comb begin
        if (r_degree == 3'd0) begin
            p_sat = BI_W'(1);
        end else if (int'(r_degree) > MAX_DEGREE) begin
            p_sat = BI_W'(MAX_DEGREE);
        end else begin
            p_sat = BI_W'(r_degree);
        end
        if (r_points < 7'd2) begin
            n_sat = IX_W'(2);
        end else if (int'(r_points) > MAX_POINTS) begin
            n_sat = IX_W'(MAX_POINTS);
        end else begin
            n_sat = IX_W'(r_points);
        end
    end

    always_comb begin
        n_degree = r_degree;
        n_points = r_points;
        if (i_cfg_we) begin
            case (i_cfg_index)
                bce_pkg::CFG_DEGREE: n_degree = i_cfg_data[2:0];
                bce_pkg::CFG_POINTS: n_points = i_cfg_data;
                default: ;
            endcase
        end
    end

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[IX_W:1];
    assign kq_sh   = KA_W'(r_knot_q) << FRAME_FRAC_BITS;
    assign ka_sh   = KA_W'(r_ka) << FRAME_FRAC_BITS;
    assign t_ge_kq = DIFF_W'(r_t) >= DIFF_W'(kq_sh);
    assign dk      = $signed({1'b0, r_knot_q}) - $signed({1'b0, r_ka});
    assign diff    = $signed({1'b0, DIFF_W'(r_t)}) - $signed({1'b0, DIFF_W'(ka_sh)});
    assign diff_mag = diff[DIFF_W] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign dvd_full = {diff_mag, 16'b0} >> FRAME_FRAC_BITS;

    // two restoring divide steps per cycle
    always_comb begin
        d_rem   = r_rem;
        d_dvd   = r_dvd;
        d_quot  = r_quot;
        d_trial = '0;
        for (int k = 0; k < 2; k++) begin
            d_trial = {d_rem, d_dvd[DW_E-1]};
            d_dvd   = d_dvd << 1;
            if (d_trial >= {1'b0, r_dvs}) begin
                d_trial = d_trial - {1'b0, r_dvs};
                d_quot  = {d_quot[DW_E-2:0], 1'b1};
            end else begin
                d_quot  = {d_quot[DW_E-2:0], 1'b0};
            end
            d_rem = d_trial[7:0];
        end
    end

    assign mul_lo = r_old * $signed({1'b0, r_a[16:0]});
    assign mul_hi = r_old * $signed(r_a[A_W-1:17]);

    always_comb begin
        prod_r  = r_prod + P_W'(bce_pkg::HALF_Q16);
        tmp_rnd = R_W'(prod_r >>> 16);
        if (tmp_rnd > RW_MAX) begin
            tmp_sat = bce_pkg::t_weight'(bce_pkg::W18_MAX);
        end else if (tmp_rnd < RW_MIN) begin
            tmp_sat = bce_pkg::t_weight'(bce_pkg::W18_MIN);
        end else begin
            tmp_sat = tmp_rnd[17:0];
        end
        upd_sum = S_W'(r_carry) + S_W'(r_old) - S_W'(tmp_rnd);
        if (upd_sum > SW_MAX) begin
            upd_sat = bce_pkg::t_weight'(bce_pkg::W18_MAX);
        end else if (upd_sum < SW_MIN) begin
            upd_sat = bce_pkg::t_weight'(bce_pkg::W18_MIN);
        end else begin
            upd_sat = upd_sum[17:0];
        end
    end

    always_comb begin
        case (r_c)
            2'd0:    mac_comp = r_ctrl_q.x;
            2'd1:    mac_comp = r_ctrl_q.y;
            2'd2:    mac_comp = r_ctrl_q.z;
            default: mac_comp = r_ctrl_q.w;
        endcase
    end
    assign mac_p = mac_comp * r_basis_q;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc_r[k]   = r_acc[k] + ACC_W'(bce_pkg::HALF_Q16);
            acc_rnd[k] = AR_W'(acc_r[k] >>> 16);
            if (acc_rnd[k] > OUT_MAX) begin
                acc_out[k] = 32'sh7fffffff;
            end else if (acc_rnd[k] < OUT_MIN) begin
                acc_out[k] = 32'sh80000000;
            end else begin
                acc_out[k] = acc_rnd[k][31:0];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bce_pkg::ST_IDLE: begin
                if (accept && i_item.kind == bce_pkg::KIND_EVAL) begin
                    if (int'(n_sat) <= int'(p_sat)) begin
                        n_state = bce_pkg::ST_FIN;
                    end else begin
                        n_state = bce_pkg::ST_LOOK_N;
                    end
                end
            end
            bce_pkg::ST_LOOK_N:  n_state = bce_pkg::ST_CMP_N;
            bce_pkg::ST_CMP_N:   n_state = t_ge_kq ? bce_pkg::ST_INIT : bce_pkg::ST_CMP_P;
            bce_pkg::ST_CMP_P:   n_state = t_ge_kq ? bce_pkg::ST_BIS_RD : bce_pkg::ST_INIT;
            bce_pkg::ST_BIS_RD: begin
                n_state = (r_hi - r_lo > IX_W'(1)) ? bce_pkg::ST_BIS_CMP : bce_pkg::ST_INIT;
            end
            bce_pkg::ST_BIS_CMP: n_state = bce_pkg::ST_BIS_RD;
            bce_pkg::ST_INIT:    n_state = bce_pkg::ST_RD_A;
            bce_pkg::ST_RD_A:    n_state = bce_pkg::ST_RD_B;
            bce_pkg::ST_RD_B:    n_state = bce_pkg::ST_DEN;
            bce_pkg::ST_DEN:     n_state = (dk == 9'sd0) ? bce_pkg::ST_FIN : bce_pkg::ST_DIV;
            bce_pkg::ST_DIV: begin
                if (r_dcnt == DC_W'(1)) begin
                    n_state = bce_pkg::ST_SIGN;
                end
            end
            bce_pkg::ST_SIGN:    n_state = bce_pkg::ST_MUL_LO;
            bce_pkg::ST_MUL_LO:  n_state = bce_pkg::ST_MUL_HI;
            bce_pkg::ST_MUL_HI:  n_state = bce_pkg::ST_UPD;
            bce_pkg::ST_UPD: begin
                n_state = (r_j == '0) ? bce_pkg::ST_WR0 : bce_pkg::ST_RD_A;
            end
            bce_pkg::ST_WR0: begin
                n_state = (r_i == r_p) ? bce_pkg::ST_SUM_RD : bce_pkg::ST_RD_A;
            end
            bce_pkg::ST_SUM_RD:  n_state = bce_pkg::ST_SUM_MAC;
            bce_pkg::ST_SUM_MAC: begin
                if (r_c == 2'd3) begin
                    n_state = (r_j == r_p) ? bce_pkg::ST_FIN : bce_pkg::ST_SUM_RD;
                end
            end
            bce_pkg::ST_FIN:     n_state = bce_pkg::ST_IDLE;
            default:             n_state = bce_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_t = r_t; n_p = r_p; n_n = r_n; n_s = r_s; n_lo = r_lo; n_hi = r_hi;
        n_i = r_i; n_j = r_j; n_c = r_c; n_err = r_err; n_ka = r_ka;
        n_old = r_old; n_carry = r_carry; n_dvd = r_dvd; n_quot = r_quot;
        n_rem = r_rem; n_dvs = r_dvs; n_neg = r_neg; n_dcnt = r_dcnt;
        n_a = r_a; n_prod = r_prod;
        n_result = r_result; n_result_valid = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n_acc[k] = r_acc[k];
        end
        knot_we  = 1'b0; knot_wa  = IX_W'(i_item.slot);
        knot_re  = 1'b0; knot_ra  = r_n;
        ctrl_we  = 1'b0; ctrl_wa  = CI_W'(i_item.slot);
        ctrl_re  = 1'b0; ctrl_ra  = CI_W'(r_s - IX_W'(r_j));
        basis_we = 1'b0; basis_wa = '0; basis_wd = r_carry;
        basis_re = 1'b0; basis_ra = r_j;
        case (r_state)
            bce_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_item.kind)
                        bce_pkg::KIND_KNOT:  knot_we = int'(i_item.slot) < KNOT_DEPTH;
                        bce_pkg::KIND_POINT: ctrl_we = int'(i_item.slot) < MAX_POINTS;
                        bce_pkg::KIND_EVAL: begin
                            n_t   = i_item.frame_time;
                            n_p   = p_sat;
                            n_n   = n_sat;
                            n_s   = '0;
                            n_err = int'(n_sat) <= int'(p_sat);
                            for (int k = 0; k < 4; k++) begin
                                n_acc[k] = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bce_pkg::ST_LOOK_N: knot_re = 1'b1;
            bce_pkg::ST_CMP_N: begin
                knot_re = 1'b1;
                knot_ra = IX_W'(r_p);
                if (t_ge_kq) begin
                    n_s = r_n - IX_W'(1);
                end
            end
            bce_pkg::ST_CMP_P: begin
                if (t_ge_kq) begin
                    n_lo = IX_W'(r_p);
                    n_hi = r_n;
                end else begin
                    n_s = IX_W'(r_p);
                end
            end
            bce_pkg::ST_BIS_RD: begin
                knot_re = 1'b1;
                knot_ra = mid;
                n_s     = r_lo;
            end
            bce_pkg::ST_BIS_CMP: begin
                if (t_ge_kq) begin
                    n_lo = mid;
                end else begin
                    n_hi = mid;
                end
            end
            bce_pkg::ST_INIT: begin
                basis_we = 1'b1;
                basis_wd = bce_pkg::t_weight'(bce_pkg::ONE_Q16);
                n_i      = BI_W'(1);
                n_j      = '0;
                n_carry  = '0;
            end
            bce_pkg::ST_RD_A: begin
                knot_re  = 1'b1;
                knot_ra  = r_s - IX_W'(r_j);
                basis_re = 1'b1;
            end
            bce_pkg::ST_RD_B: begin
                n_ka    = r_knot_q;
                knot_re = 1'b1;
                knot_ra = r_s + IX_W'(r_i) - IX_W'(r_j);
            end
            bce_pkg::ST_DEN: begin
                if (dk == 9'sd0) begin
                    n_err = 1'b1;
                end else begin
                    n_neg  = diff[DIFF_W] ^ dk[8];
                    n_dvd  = DW_E'(dvd_full);
                    n_dvs  = dk[8] ? 8'(-dk) : dk[7:0];
                    n_rem  = '0;
                    n_quot = '0;
                    n_dcnt = DC_W'(DIV_STEPS);
                    n_old  = r_basis_q;
                end
            end
            bce_pkg::ST_DIV: begin
                n_rem  = d_rem;
                n_dvd  = d_dvd;
                n_quot = d_quot;
                n_dcnt = r_dcnt - DC_W'(1);
            end
            bce_pkg::ST_SIGN: begin
                n_a = r_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});
            end
            bce_pkg::ST_MUL_LO: n_prod = P_W'(mul_lo);
            bce_pkg::ST_MUL_HI: n_prod = r_prod + (P_W'(mul_hi) <<< 17);
            bce_pkg::ST_UPD: begin
                basis_we = 1'b1;
                basis_wa = r_j + BI_W'(1);
                basis_wd = upd_sat;
                n_carry  = tmp_sat;
                if (r_j != '0) begin
                    n_j = r_j - BI_W'(1);
                end
            end
            bce_pkg::ST_WR0: begin
                basis_we = 1'b1;
                // the top weight of the next round starts at zero
                n_carry  = '0;
                if (r_i == r_p) begin
                    n_j = '0;
                end else begin
                    n_i = r_i + BI_W'(1);
                    n_j = r_i;
                end
            end
            bce_pkg::ST_SUM_RD: begin
                ctrl_re  = 1'b1;
                basis_re = 1'b1;
                n_c      = '0;
            end
            bce_pkg::ST_SUM_MAC: begin
                n_acc[r_c] = r_acc[r_c] + ACC_W'(mac_p);
                n_c        = r_c + 2'd1;
                if (r_c == 2'd3 && r_j != r_p) begin
                    n_j = r_j + BI_W'(1);
                end
            end
            bce_pkg::ST_FIN: begin
                n_result_valid           = 1'b1;
                n_result.span_index      = 6'(r_s);
                n_result.zero_span_error = r_err;
                n_result.curve_x         = r_err ? '0 : acc_out[0];
                n_result.curve_y         = r_err ? '0 : acc_out[1];
                n_result.curve_z         = r_err ? '0 : acc_out[2];
                n_result.curve_w         = r_err ? '0 : acc_out[3];
            end
            default: ;
        endcase
    end

    // memories; a read and a write of the same entry never share a cycle
    always_ff @(posedge i_clk) begin
        if (knot_we) begin
            knot_mem[knot_wa] <= i_item.knot_value;
        end
        if (knot_re) begin
            r_knot_q <= knot_mem[knot_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_we) begin
            ctrl_mem[ctrl_wa] <= '{x: i_item.point_x_in, y: i_item.point_y_in,
                                   z: i_item.point_z_in, w: i_item.point_w_in};
        end
        if (ctrl_re) begin
            r_ctrl_q <= ctrl_mem[ctrl_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (basis_we) begin
            basis_mem[basis_wa] <= basis_wd;
        end
        if (basis_re) begin
            r_basis_q <= basis_mem[basis_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= bce_pkg::ST_IDLE;
            r_degree       <= 3'(bce_pkg::DEGREE_RESET);
            r_points       <= 7'(bce_pkg::POINTS_RESET);
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_degree       <= n_degree;
            r_points       <= n_points;
            r_result_valid <= n_result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t; r_p <= n_p; r_n <= n_n; r_s <= n_s; r_lo <= n_lo; r_hi <= n_hi;
        r_i <= n_i; r_j <= n_j; r_c <= n_c; r_err <= n_err; r_ka <= n_ka;
        r_old <= n_old; r_carry <= n_carry; r_dvd <= n_dvd; r_quot <= n_quot;
        r_rem <= n_rem; r_dvs <= n_dvs; r_neg <= n_neg; r_dcnt <= n_dcnt;
        r_a <= n_a; r_prod <= n_prod; r_result <= n_result;
        for (int k = 0; k < 4; k++) begin
            r_acc[k] <= n_acc[k];
        end
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy && $past(busy))
        else $error("result strobe without a finished evaluation");

    a_busy_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start) && $past(i_item.kind) == bce_pkg::KIND_EVAL)
        else $error("busy raised by a non-evaluate transaction");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.zero_span_error |->
            o_result.curve_x == 0 && o_result.curve_y == 0 &&
            o_result.curve_z == 0 && o_result.curve_w == 0)
        else $error("error result carries nonzero curve values");

endmodule
